### rtl/core/aip_pkg.sv
// Package for the ASCII integer parser: parse phase codes, character codes,
// parser state and result types. No dependencies.
package aip_pkg;

  localparam int unsigned ACC_W = 64;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGNED = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DEC    = 3'd3,
    PH_OCT    = 3'd4,
    PH_HEX    = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  typedef struct packed {
    phase_t             phase;
    logic               neg;
    logic [ACC_W-1:0]   acc;
  } parse_state_t;

  typedef struct packed {
    logic               neg;
    logic [ACC_W-1:0]   mag;
  } aip_result_t;

  localparam parse_state_t ST_IDLE = '{phase: PH_LEAD, neg: 1'b0, acc: '0};

endpackage

### rtl/core/aip_step.sv
// Next-state logic of the parser for one character: classify the character
// and shift-add the digit into the accumulator. Depends on aip_pkg.
module aip_step
  import aip_pkg::*;
(
  input  logic [7:0]   char_code,
  input  parse_state_t cur,
  output parse_state_t nxt
);

  logic             is_blank;
  logic             is_dec;
  logic             is_oct;
  logic             is_hex;
  logic [3:0]       dec_d;
  logic [3:0]       hex_d;
  logic [ACC_W-1:0] acc_x8;
  logic [ACC_W-1:0] acc_x10;
  logic [ACC_W-1:0] acc_x16;

  always_comb begin
    is_blank = (char_code == CH_SPACE) || (char_code == CH_TAB);
    is_dec   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    is_oct   = (char_code >= CH_ZERO) && (char_code <= CH_SEVEN);
    dec_d    = 4'(char_code - CH_ZERO);
    is_hex   = 1'b1;
    if (is_dec) begin
      hex_d = dec_d;
    end else if ((char_code >= CH_LA) && (char_code <= CH_LF)) begin
      hex_d = 4'(char_code - CH_LA + HEX_TEN);
    end else if ((char_code >= CH_UA) && (char_code <= CH_UF)) begin
      hex_d = 4'(char_code - CH_UA + HEX_TEN);
    end else begin
      hex_d  = 4'd0;
      is_hex = 1'b0;
    end
    acc_x8  = {cur.acc[ACC_W-4:0], 3'b000};
    acc_x10 = {cur.acc[ACC_W-4:0], 3'b000} + {cur.acc[ACC_W-2:0], 1'b0};
    acc_x16 = {cur.acc[ACC_W-5:0], 4'b0000};

    nxt = cur;
    case (cur.phase)
      PH_LEAD, PH_SIGNED: begin
        if (is_blank) begin
          nxt.phase = cur.phase;
        end else if ((cur.phase == PH_LEAD) &&
                     ((char_code == CH_MINUS) || (char_code == CH_PLUS))) begin
          nxt.neg   = (char_code == CH_MINUS);
          nxt.phase = PH_SIGNED;
        end else if (char_code == CH_ZERO) begin
          nxt.phase = PH_ZERO;
        end else if (is_dec) begin
          nxt.acc   = {{(ACC_W-4){1'b0}}, dec_d};
          nxt.phase = PH_DEC;
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      PH_ZERO: begin
        if ((char_code == CH_LX) || (char_code == CH_UX)) begin
          nxt.phase = PH_HEX;
        end else if (is_oct) begin
          nxt.acc   = acc_x8 + {{(ACC_W-4){1'b0}}, dec_d};
          nxt.phase = PH_OCT;
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      PH_DEC: begin
        if (is_dec) begin
          nxt.acc = acc_x10 + {{(ACC_W-4){1'b0}}, dec_d};
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      PH_OCT: begin
        if (is_oct) begin
          nxt.acc = acc_x8 + {{(ACC_W-4){1'b0}}, dec_d};
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      PH_HEX: begin
        if (is_hex) begin
          nxt.acc = acc_x16 + {{(ACC_W-4){1'b0}}, hex_d};
        end else begin
          nxt.phase = PH_DONE;
        end
      end
      default: begin
        nxt.phase = PH_DONE;
      end
    endcase
  end

endmodule

### rtl/core/aip_accum.sv
// Input register and parser state: takes one character beat per cycle unless a last beat waits
// on a full result stage, and hands the finished magnitude and sign on. Depends on aip_pkg, aip_step.
module aip_accum
  import aip_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  char_code,
  input  logic        end_of_text,
  output logic        res_valid,
  output aip_result_t res,
  input  logic        res_take
);

  logic         a_valid;
  logic [7:0]   a_char;
  logic         a_last;
  parse_state_t st;
  parse_state_t st_next;
  logic         c_free;
  logic         a_consume;
  logic         a_free;

  aip_step u_step (
    .char_code (a_char),
    .cur       (st),
    .nxt       (st_next)
  );

  assign c_free     = !res_valid || res_take;
  assign a_consume  = a_valid && (!a_last || c_free);
  assign a_free     = !a_valid || a_consume;
  assign char_stall = !a_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      st        <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid <= char_valid;
      end
      if (a_consume) begin
        st <= a_last ? ST_IDLE : st_next;
      end
      if (a_consume && a_last) begin
        res_valid <= 1'b1;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && char_valid) begin
      a_char <= char_code;
      a_last <= end_of_text;
    end
    if (a_consume && a_last) begin
      res.neg <= st_next.neg;
      res.mag <= st_next.acc;
    end
  end

`ifndef SYNTHESIS
  a_prefix_acc_zero: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_LEAD || st.phase == PH_SIGNED || st.phase == PH_ZERO) |-> st.acc == '0)
    else $error("accumulator nonzero before first digit");
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (a_consume && a_last) |=> st == ST_IDLE)
    else $error("parser not restarted after last beat");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_take) |=> (res_valid && $stable(res)))
    else $error("pending result lost or changed");
  a_last_hold: assert property (@(posedge clk) disable iff (rst)
    (a_valid && a_last && !c_free) |=> (a_valid && a_last && $stable(a_char)))
    else $error("last character dropped while result stage full");
`endif

endmodule

### rtl/core/aip_out.sv
// Output register: applies the sign to the finished magnitude and holds the
// result beat until taken. Depends on aip_pkg.
module aip_out
  import aip_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    res_valid,
  input  aip_result_t             res,
  output logic                    res_take,
  output logic                    value_valid,
  input  logic                    value_stall,
  output logic signed [ACC_W-1:0] parsed_value
);

  logic [ACC_W-1:0] neg_mag;

  assign res_take = !value_valid || !value_stall;
  assign neg_mag  = {ACC_W{1'b0}} - res.mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_valid <= 1'b0;
    end else if (res_take) begin
      value_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      parsed_value <= res.neg ? $signed(neg_mag) : $signed(res.mag);
    end
  end

endmodule

### rtl/core/ascii_integer_parser_top.sv
// ASCII integer parser: takes one character per beat and accepts a new
// character every cycle unless char_stall holds it back. After leading blanks and
// an optional sign, "0x" or "0X" selects hex, a leading 0 octal, else decimal;
// the first character that does not fit ends the number. The beat that carries
// end_of_text passes the input register, then the result register, and its value
// appears from the output register as a 64-bit two's complement number wrapped
// modulo 2^64. The rate rests on the combinational shift-add of the accumulator;
// negation sits in the output stage. Depends on aip_pkg, aip_accum, aip_out.
module ascii_integer_parser_top
  import aip_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    char_valid,
  output logic                    char_stall,
  input  logic [7:0]              char_code,
  input  logic                    end_of_text,
  output logic                    value_valid,
  input  logic                    value_stall,
  output logic signed [ACC_W-1:0] parsed_value
);

  logic        res_valid;
  aip_result_t res;
  logic        res_take;

  aip_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .res_valid   (res_valid),
    .res         (res),
    .res_take    (res_take)
  );

  aip_out u_out (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (res_valid),
    .res          (res),
    .res_take     (res_take),
    .value_valid  (value_valid),
    .value_stall  (value_stall),
    .parsed_value (parsed_value)
  );

endmodule

### tb/ascii_integer_parser_top_tb.sv
// Testbench for ascii_integer_parser_top: directed and random character texts,
// each result checked against an in-bench parser model.
// Depends on aip_pkg and ascii_integer_parser_top.
module ascii_integer_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aip_pkg::*;

  localparam int unsigned HALF_PERIOD  = 5;
  localparam int unsigned IDLE_PCT     = 19;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_CHARS = 500;

  logic                    clk         = 1'b0;
  logic                    rst         = 1'b1;
  logic                    char_valid  = 1'b0;
  logic                    char_stall;
  logic [7:0]              char_code   = '0;
  logic                    end_of_text = 1'b0;
  logic                    value_valid;
  logic                    value_stall = 1'b0;
  logic signed [ACC_W-1:0] parsed_value;

  phase_t                  parse_phase;
  logic                    minus_seen;
  logic [ACC_W-1:0]        magnitude;
  logic signed [ACC_W-1:0] expected_values[$];
  logic signed [ACC_W-1:0] want_value;
  int unsigned             mismatches   = 0;
  int unsigned             chars_sent   = 0;
  int unsigned             quiet_cycles = 0;
  bit                      calm         = 1'b0;

  ascii_integer_parser_top u_top (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_code    (char_code),
    .end_of_text  (end_of_text),
    .value_valid  (value_valid),
    .value_stall  (value_stall),
    .parsed_value (parsed_value)
  );

  always #HALF_PERIOD clk = ~clk;

  task automatic report_mismatch(input string what, input logic [ACC_W-1:0] got,
                                 input logic [ACC_W-1:0] want);
    $display("mismatch at %0t: %s, got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic clear_parser();
    parse_phase = PH_LEAD;
    minus_seen  = 1'b0;
    magnitude   = '0;
  endtask

  task automatic start_number(input logic [7:0] c);
    if (c == CH_ZERO) begin
      parse_phase = PH_ZERO;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      magnitude   = ACC_W'(c - CH_ZERO);
      parse_phase = PH_DEC;
    end else begin
      parse_phase = PH_DONE;
    end
  endtask

  task automatic parse_char(input logic [7:0] c, input logic last);
    case (parse_phase)
      PH_LEAD: begin
        if (c != CH_SPACE && c != CH_TAB) begin
          if (c == CH_MINUS || c == CH_PLUS) begin
            minus_seen  = (c == CH_MINUS);
            parse_phase = PH_SIGNED;
          end else begin
            start_number(c);
          end
        end
      end
      PH_SIGNED: begin
        if (c != CH_SPACE && c != CH_TAB) start_number(c);
      end
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          parse_phase = PH_HEX;
        end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
          magnitude   = magnitude * 8 + (c - CH_ZERO);
          parse_phase = PH_OCT;
        end else begin
          parse_phase = PH_DONE;
        end
      end
      PH_DEC: begin
        if (c >= CH_ZERO && c <= CH_NINE) magnitude = magnitude * 10 + (c - CH_ZERO);
        else parse_phase = PH_DONE;
      end
      PH_OCT: begin
        if (c >= CH_ZERO && c <= CH_SEVEN) magnitude = magnitude * 8 + (c - CH_ZERO);
        else parse_phase = PH_DONE;
      end
      PH_HEX: begin
        if (c >= CH_ZERO && c <= CH_NINE) magnitude = magnitude * 16 + (c - CH_ZERO);
        else if (c >= CH_LA && c <= CH_LF) magnitude = magnitude * 16 + (c - CH_LA + HEX_TEN);
        else if (c >= CH_UA && c <= CH_UF) magnitude = magnitude * 16 + (c - CH_UA + HEX_TEN);
        else parse_phase = PH_DONE;
      end
      default: parse_phase = PH_DONE;
    endcase
    if (last) begin
      expected_values.push_back(minus_seen ? -magnitude : magnitude);
      clear_parser();
    end
  endtask

  task automatic send_char(input logic [7:0] c, input logic last);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        char_valid <= 1'b0;
        @(posedge clk);
      end
    end
    char_valid  <= 1'b1;
    char_code   <= c;
    end_of_text <= last;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    parse_char(c, last);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic test_decimal();
    send_text("7");
    send_text(" \t-12");
  endtask

  task automatic test_prefixes();
    send_text("0X1fF");
    send_text("017");
    send_text("0");
    send_text("0x");
  endtask

  task automatic test_stop_cases();
    send_text("+");
    send_text("-5-3");
    send_text("+-");
    send_char(8'h00, 1'b1);
    send_char(8'hff, 1'b1);
  endtask

  task automatic send_random_text();
    logic [7:0]  text[$];
    int unsigned n_digits;
    int unsigned d;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) text.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 2)) text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      case ($urandom_range(0, 2))
        1: text.push_back(CH_PLUS);
        2: text.push_back(CH_MINUS);
        default: ;
      endcase
      repeat ($urandom_range(0, 1)) text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      n_digits = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 24) : $urandom_range(1, 6);
      case ($urandom_range(0, 2))
        0: begin
          text.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
          repeat (n_digits - 1) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        1: begin
          text.push_back(CH_ZERO);
          repeat (n_digits - 1) text.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
        end
        default: begin
          text.push_back(CH_ZERO);
          text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
          repeat (n_digits) begin
            d = $urandom_range(0, 21);
            if (d < 10) text.push_back(CH_ZERO + 8'(d));
            else if (d < 16) text.push_back(CH_LA + 8'(d - 10));
            else text.push_back(CH_UA + 8'(d - 16));
          end
        end
      endcase
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) text.push_back(8'($urandom));
      // corrupt one position to break the sequence
      if ($urandom_range(0, 6) == 0) text[$urandom_range(0, text.size() - 1)] = 8'($urandom);
    end
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic test_random_texts();
    int unsigned first;
    first = chars_sent;
    while (chars_sent - first < RANDOM_CHARS) begin
      calm = (chars_sent - first >= 200 && chars_sent - first < 350);
      send_random_text();
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    value_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && value_valid && !value_stall) begin
      if (expected_values.size() == 0) begin
        report_mismatch("value with none expected", parsed_value, '0);
      end else begin
        want_value = expected_values.pop_front();
        if (parsed_value !== want_value) report_mismatch("parsed_value", parsed_value, want_value);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (value_valid && !value_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL ascii_integer_parser_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_parser();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_decimal();
    test_prefixes();
    test_stop_cases();
    test_random_texts();
    char_valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS ascii_integer_parser_top");
    end else begin
      $display("FAIL ascii_integer_parser_top");
    end
    $finish;
  end

endmodule
